FILE: hdl/tpmt_pkg.sv
// -----------------------------------------------------------------------------
// tpmt_pkg - shared types and constants of the trapezoid profile timer
// Field widths, register indexes, status codes and the records that pass
// from the front part through the queue to the back part.
// -----------------------------------------------------------------------------
package tpmt_pkg;

   localparam int SPEED_W = 24;
   localparam int LEN_W   = 32;
   localparam int TIME_W  = 32;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 2;
   localparam int SQ_W    = 48;   // square of a speed, product of two limits
   localparam int PEAK_NUM_W = 82; // 2*A*D*L + D*V0^2 + A*V1^2
   localparam int PEAK_SQ_W  = 58; // peak speed squared
   localparam int PEAK_W     = 29; // peak speed
   localparam int FIN_NUM_W  = 63;
   localparam int FIN_DEN_W  = 48;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_SPEED_CAP   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_ACCEL_LIMIT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_DECEL_LIMIT = 2'd2;

   localparam logic [SPEED_W-1:0] SPEED_CAP_RST   = 24'd65536;
   localparam logic [SPEED_W-1:0] ACCEL_LIMIT_RST = 24'd32768;
   localparam logic [SPEED_W-1:0] DECEL_LIMIT_RST = 24'd32768;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STAT_W-1:0] ST_SHORT    = 2'd2;
   localparam logic [STAT_W-1:0] ST_PEAK_LOW = 2'd3;

   localparam logic [TIME_W-1:0] TIME_ONES = '1;

   typedef struct packed {
      logic [LEN_W-1:0]   path_length;
      logic [SPEED_W-1:0] speed_start;
      logic [SPEED_W-1:0] speed_end;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] travel_time;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_cap;
      logic [SPEED_W-1:0] accel_limit;
      logic [SPEED_W-1:0] decel_limit;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic                  fixed;      // result settled without arithmetic
      logic [STAT_W-1:0]     fix_status;
      logic                  fix_zero;   // settled time is zero, not all ones
      logic                  trap;       // cruise phase fits
      logic [LEN_W-1:0]      path_length;
      logic [SPEED_W-1:0]    speed_start;
      logic [SPEED_W-1:0]    speed_end;
      logic [PEAK_NUM_W-1:0] peak_num;
      logic [SQ_W-1:0]       e0sq;       // (Vm-V0)^2
      logic [SQ_W-1:0]       e1sq;       // (Vm-V1)^2
      logic [SQ_W-1:0]       avm;        // A*Vm
      logic [SQ_W-1:0]       dvm;        // D*Vm
   } queue_entry_type;

   typedef struct packed {
      logic              fixed;
      logic [STAT_W-1:0] fix_status;
      logic              fix_zero;
      logic              peak_low;
   } fin_tag_type;

endpackage

FILE: hdl/trapezoid_profile_min_time_core.sv
// -----------------------------------------------------------------------------
// trapezoid_profile_min_time_core - minimum travel time over one segment
// Trapezoidal or triangular speed profile under a speed cap and separate
// acceleration and deceleration limits, with infeasibility status.
// -----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  request   start / busy         req_data: path_length, entry/exit speed
//  response  rsp_valid strobe     rsp_data: travel_time, status
//  csr       csr_valid/csr_ready  csr_index, csr_data (24-bit limits)
//
//  One item is taken per cycle whenever busy is low; results leave in order
//  after five front stages, one queue stage, the bit-per-stage divider for
//  the peak speed squared (59 stages), its square root (30 stages), one
//  operand stage, the phase-time divider (33 stages) and the output register.
//  Synchronous reset empties all pipelines and the queue and loads the limits
//  with their defaults. The receiver cannot stall, so the back part pops the
//  queue whenever it is not empty; busy rises only if queue plus front could
//  reach the queue depth, which never happens at the default depth.
//
module trapezoid_profile_min_time_core #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    start,
   output logic                    busy,
   input  tpmt_pkg::req_type       req_data,
   // response channel
   output logic                    rsp_valid,
   output tpmt_pkg::rsp_type       rsp_data,
   // configuration channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [23:0]             csr_data
);
   import tpmt_pkg::*;

   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_W = CNT_W + 3;

   cfg_type           cfg_ff, cfg_in;
   logic              accept;
   logic              push;
   queue_entry_type   push_entry;
   logic [2:0]        inflight;
   logic              q_valid;
   queue_entry_type   q_entry;
   logic [CNT_W-1:0]  q_count;
   logic [FILL_W-1:0] fill;

   // limit registers; csr_ready is tied high, so writes are always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPEED_CAP:   cfg_in.speed_cap   = csr_data;
            CSR_ACCEL_LIMIT: cfg_in.accel_limit = csr_data;
            CSR_DECEL_LIMIT: cfg_in.decel_limit = csr_data;
            default:         ;  // unused index: drop the transfer
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_cap   <= SPEED_CAP_RST;
         cfg_ff.accel_limit <= ACCEL_LIMIT_RST;
         cfg_ff.decel_limit <= DECEL_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold off new requests once the queue plus everything in the front
   // pipeline could fill it
   assign fill   = FILL_W'(q_count) + FILL_W'(inflight);
   assign busy   = (fill >= FILL_W'(QUEUE_DEPTH));
   assign accept = start && !busy;

   tpmt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .push     (push),
      .entry    (push_entry),
      .inflight (inflight)
   );

   // the back part never stalls: pop the head whenever there is one
   tpmt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (q_valid),
      .out_valid (q_valid),
      .out_data  (q_entry),
      .count     (q_count)
   );

   tpmt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_entry  (q_entry),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/tpmt_front.sv
// -----------------------------------------------------------------------------
// tpmt_front - accept and classify
// Five-stage pipeline: squares and products of the speeds and limits, the
// feasibility checks, the trapezoid test and the peak-speed numerator.
// -----------------------------------------------------------------------------
module tpmt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  tpmt_pkg::req_type         req_data,
   input  tpmt_pkg::cfg_type         cfg,
   output logic                      push,
   output tpmt_pkg::queue_entry_type entry,
   output logic [2:0]                inflight
);
   import tpmt_pkg::*;

   typedef struct packed {
      req_type         req;
      logic            invalid;
      logic            lzero;
      logic            bothzero;
      logic            short_path;
      logic [SQ_W-1:0] e0sq;
      logic [SQ_W-1:0] e1sq;
      logic [SQ_W-1:0] avm;
      logic [SQ_W-1:0] dvm;
   } carry_type;

   logic                vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   req_type             req1_ff;
   carry_type           c2_in, c2_ff, c3_in, c3_ff, c4_ff, c5_ff;

   logic [SPEED_W-1:0]  e0, e1;
   logic [SQ_W-1:0]     v0sq_in, v1sq_in, vmsq_in, ad_in;
   logic [SQ_W-1:0]     v0sq_ff, v1sq_ff, vmsq_ff, ad_ff;
   logic [55:0]         al_in, dl_in, al_ff, dl_ff;

   logic [SQ_W-1:0]     dva_in, dvb_in, dva_ff, dvb_ff;
   logic [55:0]         adl_hi_in, adl_lo_in, adl_hi_ff, adl_lo_ff;
   logic [SQ_W-1:0]     dv0_hi_in, dv0_lo_in, av1_hi_in, av1_lo_in;
   logic [SQ_W-1:0]     dv0_hi_ff, dv0_lo_ff, av1_hi_ff, av1_lo_ff;

   logic [79:0]         adl;
   logic [80:0]         rhs_in, rhs4_ff, rhs5_ff;
   logic [71:0]         dv0_in, av1_in, dv0_ff, av1_ff;
   logic [SQ_W-1:0]     la_hi_in, la_lo_in, lb_hi_in, lb_lo_in;
   logic [SQ_W-1:0]     la_hi_ff, la_lo_ff, lb_hi_ff, lb_lo_ff;

   logic [72:0]         lhs_in, lhs_ff;
   logic [PEAK_NUM_W-1:0] q_in, q_ff;

   // stage 1: products of inputs and limits
   always_comb begin
      e0      = cfg.speed_cap - req1_ff.speed_start;
      e1      = cfg.speed_cap - req1_ff.speed_end;
      v0sq_in = SQ_W'(req1_ff.speed_start) * SQ_W'(req1_ff.speed_start);
      v1sq_in = SQ_W'(req1_ff.speed_end) * SQ_W'(req1_ff.speed_end);
      vmsq_in = SQ_W'(cfg.speed_cap) * SQ_W'(cfg.speed_cap);
      ad_in   = SQ_W'(cfg.accel_limit) * SQ_W'(cfg.decel_limit);
      al_in   = 56'(cfg.accel_limit) * 56'(req1_ff.path_length);
      dl_in   = 56'(cfg.decel_limit) * 56'(req1_ff.path_length);
      c2_in.req        = req1_ff;
      c2_in.invalid    = (cfg.speed_cap == '0) || (cfg.accel_limit == '0) ||
                         (cfg.decel_limit == '0) ||
                         (req1_ff.speed_start > cfg.speed_cap) ||
                         (req1_ff.speed_end > cfg.speed_cap);
      c2_in.lzero      = (req1_ff.path_length == '0);
      c2_in.bothzero   = (req1_ff.speed_start == '0) && (req1_ff.speed_end == '0);
      c2_in.short_path = 1'b0;
      c2_in.e0sq       = SQ_W'(e0) * SQ_W'(e0);
      c2_in.e1sq       = SQ_W'(e1) * SQ_W'(e1);
      c2_in.avm        = SQ_W'(cfg.accel_limit) * SQ_W'(cfg.speed_cap);
      c2_in.dvm        = SQ_W'(cfg.decel_limit) * SQ_W'(cfg.speed_cap);
   end

   // stage 2: speed-change checks, partial products of A*D*L, D*V0^2 and A*V1^2
   always_comb begin
      c3_in = c2_ff;
      c3_in.short_path =
         ((c2_ff.req.speed_end > c2_ff.req.speed_start) &&
          (57'(v1sq_ff - v0sq_ff) > {al_ff, 1'b0})) ||
         ((c2_ff.req.speed_start > c2_ff.req.speed_end) &&
          (57'(v0sq_ff - v1sq_ff) > {dl_ff, 1'b0}));
      dva_in    = vmsq_ff - v0sq_ff;
      dvb_in    = vmsq_ff - v1sq_ff;
      adl_hi_in = 56'(ad_ff[47:24]) * 56'(c2_ff.req.path_length);
      adl_lo_in = 56'(ad_ff[23:0]) * 56'(c2_ff.req.path_length);
      dv0_hi_in = SQ_W'(cfg.decel_limit) * SQ_W'(v0sq_ff[47:24]);
      dv0_lo_in = SQ_W'(cfg.decel_limit) * SQ_W'(v0sq_ff[23:0]);
      av1_hi_in = SQ_W'(cfg.accel_limit) * SQ_W'(v1sq_ff[47:24]);
      av1_lo_in = SQ_W'(cfg.accel_limit) * SQ_W'(v1sq_ff[23:0]);
   end

   // stage 3: combine partials, start the cruise-test products
   always_comb begin
      adl      = (80'(adl_hi_ff) << 24) + 80'(adl_lo_ff);
      rhs_in   = {adl, 1'b0};
      dv0_in   = (72'(dv0_hi_ff) << 24) + 72'(dv0_lo_ff);
      av1_in   = (72'(av1_hi_ff) << 24) + 72'(av1_lo_ff);
      la_hi_in = SQ_W'(dva_ff[47:24]) * SQ_W'(cfg.decel_limit);
      la_lo_in = SQ_W'(dva_ff[23:0]) * SQ_W'(cfg.decel_limit);
      lb_hi_in = SQ_W'(dvb_ff[47:24]) * SQ_W'(cfg.accel_limit);
      lb_lo_in = SQ_W'(dvb_ff[23:0]) * SQ_W'(cfg.accel_limit);
   end

   // stage 4: cruise-test left side and peak numerator
   always_comb begin
      lhs_in = (73'(la_hi_ff) << 24) + 73'(la_lo_ff) +
               (73'(lb_hi_ff) << 24) + 73'(lb_lo_ff);
      q_in   = PEAK_NUM_W'(rhs4_ff) + PEAK_NUM_W'(dv0_ff) + PEAK_NUM_W'(av1_ff);
   end

   // stage 5: classify
   always_comb begin
      entry.fixed       = c5_ff.invalid | c5_ff.lzero | c5_ff.short_path;
      entry.fix_zero    = !c5_ff.invalid && c5_ff.lzero && c5_ff.bothzero;
      if (c5_ff.invalid) begin
         entry.fix_status = ST_INVALID;
      end else if (c5_ff.lzero && c5_ff.bothzero) begin
         entry.fix_status = ST_OK;
      end else begin
         entry.fix_status = ST_SHORT;
      end
      entry.trap        = (81'(lhs_ff) <= rhs5_ff);
      entry.path_length = c5_ff.req.path_length;
      entry.speed_start = c5_ff.req.speed_start;
      entry.speed_end   = c5_ff.req.speed_end;
      entry.peak_num    = q_ff;
      entry.e0sq        = c5_ff.e0sq;
      entry.e1sq        = c5_ff.e1sq;
      entry.avm         = c5_ff.avm;
      entry.dvm         = c5_ff.dvm;
   end

   assign push     = vld5_ff;
   assign inflight = 3'(vld1_ff) + 3'(vld2_ff) + 3'(vld3_ff) + 3'(vld4_ff) + 3'(vld5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         vld1_ff <= accept;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      req1_ff   <= req_data;
      c2_ff     <= c2_in;
      v0sq_ff   <= v0sq_in;
      v1sq_ff   <= v1sq_in;
      vmsq_ff   <= vmsq_in;
      ad_ff     <= ad_in;
      al_ff     <= al_in;
      dl_ff     <= dl_in;
      c3_ff     <= c3_in;
      dva_ff    <= dva_in;
      dvb_ff    <= dvb_in;
      adl_hi_ff <= adl_hi_in;
      adl_lo_ff <= adl_lo_in;
      dv0_hi_ff <= dv0_hi_in;
      dv0_lo_ff <= dv0_lo_in;
      av1_hi_ff <= av1_hi_in;
      av1_lo_ff <= av1_lo_in;
      c4_ff     <= c3_ff;
      rhs4_ff   <= rhs_in;
      dv0_ff    <= dv0_in;
      av1_ff    <= av1_in;
      la_hi_ff  <= la_hi_in;
      la_lo_ff  <= la_lo_in;
      lb_hi_ff  <= lb_hi_in;
      lb_lo_ff  <= lb_lo_in;
      c5_ff     <= c4_ff;
      lhs_ff    <= lhs_in;
      rhs5_ff   <= rhs4_ff;
      q_ff      <= q_in;
   end

endmodule

FILE: hdl/tpmt_queue.sv
// -----------------------------------------------------------------------------
// tpmt_queue - short shift queue between front and back
// Head always at slot zero; a push lands behind the last valid slot.
// -----------------------------------------------------------------------------
module tpmt_queue #(
   parameter int DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  tpmt_pkg::queue_entry_type         push_data,
   input  logic                              pop,
   output logic                              out_valid,
   output tpmt_pkg::queue_entry_type         out_data,
   output logic [$clog2(DEPTH+1)-1:0]        count
);
   import tpmt_pkg::*;

   localparam int CNT_W = $clog2(DEPTH+1);

   queue_entry_type   slot_ff [0:DEPTH-1];
   queue_entry_type   slot_in [0:DEPTH-1];
   logic [CNT_W-1:0]  count_ff, count_in, wr_idx;

   always_comb begin
      wr_idx = count_ff - CNT_W'(pop);
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         if (pop && (i < DEPTH-1)) begin
            slot_in[i] = slot_ff[(i < DEPTH-1) ? i+1 : i];
         end
         if (push && (CNT_W'(i) == wr_idx)) begin
            slot_in[i] = push_data;
         end
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[0];
   assign count     = count_ff;

endmodule

FILE: hdl/tpmt_divpipe.sv
// -----------------------------------------------------------------------------
// tpmt_divpipe - pipelined restoring divider, one quotient bit per stage
// Quotients that need more than QUO_W bits saturate to all ones.
// -----------------------------------------------------------------------------
module tpmt_divpipe #(
   parameter int NUM_W = 63,
   parameter int DEN_W = 48,
   parameter int QUO_W = 32,
   parameter int LANES = 1,
   parameter int TAG_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [LANES-1:0][DEN_W-1:0]   in_den,
   input  logic [TAG_W-1:0]              in_tag,
   output logic                          out_valid,
   output logic [LANES-1:0][QUO_W-1:0]   out_quo,
   output logic [TAG_W-1:0]              out_tag
);
   localparam int HI_W  = NUM_W - QUO_W;
   localparam int CMP_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;

   logic                          vld_ff [0:QUO_W];
   logic [TAG_W-1:0]              tag_ff [0:QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   rem_ff [0:QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   rem_in [0:QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   den_ff [0:QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   den_in [0:QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   low_ff [0:QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   low_in [0:QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff [0:QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_in [0:QUO_W];
   logic [LANES-1:0]              sat_ff [0:QUO_W];
   logic [LANES-1:0]              sat_in [0:QUO_W];
   logic [LANES-1:0][CMP_W-1:0]   hi_ext;
   logic [LANES-1:0][DEN_W:0]     sh     [1:QUO_W];
   logic [LANES-1:0][DEN_W:0]     diff   [1:QUO_W];
   logic [LANES-1:0]              ge     [1:QUO_W];

   always_comb begin
      // entry: upper numerator bits seed the remainder
      for (int l = 0; l < LANES; l++) begin
         hi_ext[l]    = CMP_W'(in_num[l][NUM_W-1:QUO_W]);
         rem_in[0][l] = hi_ext[l][DEN_W-1:0];
         sat_in[0][l] = (hi_ext[l] >= CMP_W'(in_den[l]));
         low_in[0][l] = in_num[l][QUO_W-1:0];
         quo_in[0][l] = '0;
         den_in[0][l] = in_den[l];
      end
      // one bit per stage
      for (int k = 1; k <= QUO_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            sh[k][l]     = {rem_ff[k-1][l], low_ff[k-1][l][QUO_W-1]};
            diff[k][l]   = sh[k][l] - {1'b0, den_ff[k-1][l]};
            ge[k][l]     = (sh[k][l] >= {1'b0, den_ff[k-1][l]});
            rem_in[k][l] = ge[k][l] ? diff[k][l][DEN_W-1:0] : sh[k][l][DEN_W-1:0];
            low_in[k][l] = {low_ff[k-1][l][QUO_W-2:0], 1'b0};
            quo_in[k][l] = {quo_ff[k-1][l][QUO_W-2:0], ge[k][l]};
            sat_in[k][l] = sat_ff[k-1][l];
            den_in[k][l] = den_ff[k-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= QUO_W; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      for (int k = 1; k <= QUO_W; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
      for (int k = 0; k <= QUO_W; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         low_ff[k] <= low_in[k];
         quo_ff[k] <= quo_in[k];
         sat_ff[k] <= sat_in[k];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = sat_ff[QUO_W][l] ? '1 : quo_ff[QUO_W][l];
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out_tag   = tag_ff[QUO_W];

endmodule

FILE: hdl/tpmt_sqrtpipe.sv
// -----------------------------------------------------------------------------
// tpmt_sqrtpipe - pipelined integer square root, one root bit per stage
// Digit-by-digit method on bit pairs; the result is the floor of the root.
// -----------------------------------------------------------------------------
module tpmt_sqrtpipe #(
   parameter int RAD_W = 58,
   parameter int TAG_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [RAD_W-1:0]      in_rad,
   input  logic [TAG_W-1:0]      in_tag,
   output logic                  out_valid,
   output logic [RAD_W/2-1:0]    out_root,
   output logic [TAG_W-1:0]      out_tag
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic                  vld_ff  [0:ROOT_W];
   logic [TAG_W-1:0]      tag_ff  [0:ROOT_W];
   logic [RAD_W-1:0]      rad_ff  [0:ROOT_W];
   logic [RAD_W-1:0]      rad_in  [0:ROOT_W];
   logic [REM_W-1:0]      rem_ff  [0:ROOT_W];
   logic [REM_W-1:0]      rem_in  [0:ROOT_W];
   logic [ROOT_W-1:0]     root_ff [0:ROOT_W];
   logic [ROOT_W-1:0]     root_in [0:ROOT_W];
   logic [REM_W+1:0]      sh      [1:ROOT_W];
   logic [REM_W+1:0]      trial   [1:ROOT_W];
   logic [REM_W+1:0]      diff    [1:ROOT_W];
   logic                  ge      [1:ROOT_W];

   always_comb begin
      rad_in[0]  = in_rad;
      rem_in[0]  = '0;
      root_in[0] = '0;
      for (int k = 1; k <= ROOT_W; k++) begin
         sh[k]      = {rem_ff[k-1], rad_ff[k-1][RAD_W-1:RAD_W-2]};
         trial[k]   = (REM_W+2)'({root_ff[k-1], 2'b01});
         diff[k]    = sh[k] - trial[k];
         ge[k]      = (sh[k] >= trial[k]);
         rem_in[k]  = ge[k] ? diff[k][REM_W-1:0] : sh[k][REM_W-1:0];
         root_in[k] = {root_ff[k-1][ROOT_W-2:0], ge[k]};
         rad_in[k]  = {rad_ff[k-1][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ROOT_W; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= ROOT_W; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= in_tag;
      for (int k = 1; k <= ROOT_W; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
      for (int k = 0; k <= ROOT_W; k++) begin
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = vld_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_tag   = tag_ff[ROOT_W];

endmodule

FILE: hdl/tpmt_back.sv
// -----------------------------------------------------------------------------
// tpmt_back - arithmetic back part
// Peak speed squared by division, its root, then the phase times by division
// in three parallel lanes (the third unused for a triangle), summed and saturated.
// -----------------------------------------------------------------------------
module tpmt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  tpmt_pkg::queue_entry_type in_entry,
   input  tpmt_pkg::cfg_type         cfg,
   output logic                      rsp_valid,
   output tpmt_pkg::rsp_type         rsp_data
);
   import tpmt_pkg::*;

   localparam int ENT_W = $bits(queue_entry_type);
   localparam int FIN_W = $bits(fin_tag_type);

   logic                          pd_valid;
   logic [PEAK_SQ_W-1:0]          pd_quo;
   logic [ENT_W-1:0]              pd_tag;
   logic                          sq_valid;
   logic [PEAK_W-1:0]             sq_root;
   logic [ENT_W-1:0]              sq_tag;
   queue_entry_type               sq_entry;

   logic                          prep_vld_ff;
   logic [2:0][FIN_NUM_W-1:0]     num_in, num_ff;
   logic [2:0][FIN_DEN_W-1:0]     den_in, den_ff;
   fin_tag_type                   ftag_in, ftag_ff;
   logic [PEAK_W-1:0]             rise0, rise1;

   logic                          fd_valid;
   logic [2:0][TIME_W-1:0]        fd_quo;
   logic [FIN_W-1:0]              fd_tag;
   fin_tag_type                   fd_ftag;
   logic [TIME_W+1:0]             sum;

   logic                          rsp_valid_ff;
   rsp_type                       rsp_in, rsp_ff;

   tpmt_divpipe #(
      .NUM_W (PEAK_NUM_W),
      .DEN_W (SPEED_W + 1),
      .QUO_W (PEAK_SQ_W),
      .LANES (1),
      .TAG_W (ENT_W)
   ) u_peak_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_num    (in_entry.peak_num),
      .in_den    ((SPEED_W+1)'(cfg.accel_limit) + (SPEED_W+1)'(cfg.decel_limit)),
      .in_tag    (in_entry),
      .out_valid (pd_valid),
      .out_quo   (pd_quo),
      .out_tag   (pd_tag)
   );

   tpmt_sqrtpipe #(
      .RAD_W (PEAK_SQ_W),
      .TAG_W (ENT_W)
   ) u_peak_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pd_valid),
      .in_rad    (pd_quo),
      .in_tag    (pd_tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   assign sq_entry = sq_tag;

   // operand setup for the phase-time dividers
   always_comb begin
      rise0            = sq_root - PEAK_W'(sq_entry.speed_start);
      rise1            = sq_root - PEAK_W'(sq_entry.speed_end);
      ftag_in.fixed      = sq_entry.fixed;
      ftag_in.fix_status = sq_entry.fix_status;
      ftag_in.fix_zero   = sq_entry.fix_zero;
      ftag_in.peak_low   = !sq_entry.trap &&
                           ((sq_root < PEAK_W'(sq_entry.speed_start)) ||
                            (sq_root < PEAK_W'(sq_entry.speed_end)));
      if (sq_entry.trap) begin
         num_in[0] = FIN_NUM_W'({sq_entry.path_length, 16'b0});
         den_in[0] = FIN_DEN_W'(cfg.speed_cap);
         num_in[1] = FIN_NUM_W'({sq_entry.e0sq, 15'b0});
         den_in[1] = sq_entry.avm;
         num_in[2] = FIN_NUM_W'({sq_entry.e1sq, 15'b0});
         den_in[2] = sq_entry.dvm;
      end else begin
         num_in[0] = FIN_NUM_W'({rise0, 16'b0});
         den_in[0] = FIN_DEN_W'(cfg.accel_limit);
         num_in[1] = FIN_NUM_W'({rise1, 16'b0});
         den_in[1] = FIN_DEN_W'(cfg.decel_limit);
         num_in[2] = '0;
         den_in[2] = FIN_DEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else begin
         prep_vld_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      ftag_ff <= ftag_in;
   end

   tpmt_divpipe #(
      .NUM_W (FIN_NUM_W),
      .DEN_W (FIN_DEN_W),
      .QUO_W (TIME_W),
      .LANES (3),
      .TAG_W (FIN_W)
   ) u_phase_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_vld_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_tag    (ftag_ff),
      .out_valid (fd_valid),
      .out_quo   (fd_quo),
      .out_tag   (fd_tag)
   );

   assign fd_ftag = fd_tag;

   // sum the phases and pick the result
   always_comb begin
      sum = (TIME_W+2)'(fd_quo[0]) + (TIME_W+2)'(fd_quo[1]) + (TIME_W+2)'(fd_quo[2]);
      if (fd_ftag.fixed) begin
         rsp_in.travel_time = fd_ftag.fix_zero ? '0 : TIME_ONES;
         rsp_in.status      = fd_ftag.fix_status;
      end else if (fd_ftag.peak_low) begin
         rsp_in.travel_time = TIME_ONES;
         rsp_in.status      = ST_PEAK_LOW;
      end else begin
         rsp_in.travel_time = (sum[TIME_W+1:TIME_W] != 2'b00) ? TIME_ONES
                                                               : sum[TIME_W-1:0];
         rsp_in.status      = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fd_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/tpmt_checker.sv
// -----------------------------------------------------------------------------
// tpmt_checker - port-level checks on the profile timer
// Watches the top-level ports only; attached by the bind below.
// -----------------------------------------------------------------------------
module tpmt_port_checks (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tpmt_pkg::req_type req_data,
   input logic              rsp_valid,
   input tpmt_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [1:0]        csr_index,
   input logic [23:0]       csr_data
);
   import tpmt_pkg::*;

   // any failing status carries the saturated time
   a_fail_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.travel_time == TIME_ONES))
      else $error("failing status without saturated time");

   // reset flushes every pending result
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // reset empties the queue and the front pipeline
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy)
      else $error("busy right after reset");

endmodule

bind trapezoid_profile_min_time_core tpmt_port_checks u_checker (.*);

FILE: sim/tpmt_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tpmt_checker - response scoreboard for the trapezoid profile timer
// Watches the request, response and csr channels, predicts the travel time
// and status of every accepted request, and compares responses in order.
// -----------------------------------------------------------------------------
module tpmt_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  tpmt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  tpmt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_data,
   output int                error_count,
   output int                pending
);
   import tpmt_pkg::*;

   logic [SPEED_W-1:0] lim_speed, lim_accel, lim_decel;
   rsp_type            expected_times[$];

   function automatic logic [127:0] sat_time(logic [127:0] x);
      return (x > 128'hFFFF_FFFF) ? 128'hFFFF_FFFF : x;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic rsp_type predict_travel(req_type r);
      logic [127:0] vm, a, d, v0, v1, len, lhs, rhs, q, p, sum;
      rsp_type      o;
      vm  = lim_speed;
      a   = lim_accel;
      d   = lim_decel;
      v0  = r.speed_start;
      v1  = r.speed_end;
      len = r.path_length;
      o.status      = ST_INVALID;
      o.travel_time = TIME_ONES;
      if (vm == 0 || a == 0 || d == 0 || v0 > vm || v1 > vm) return o;
      o.status = ST_SHORT;
      if (len == 0) begin
         if (v0 == 0 && v1 == 0) begin
            o.status      = ST_OK;
            o.travel_time = '0;
         end
         return o;
      end
      if (v1 > v0 && v1 * v1 - v0 * v0 > 2 * a * len) return o;
      if (v0 > v1 && v0 * v0 - v1 * v1 > 2 * d * len) return o;
      o.status = ST_OK;
      lhs = (vm * vm - v0 * v0) * d + (vm * vm - v1 * v1) * a;
      rhs = 2 * a * d * len;
      if (lhs <= rhs) begin
         // cruise phase fits: ramp up, cruise at the cap, ramp down
         sum = sat_time((len << 16) / vm)
             + sat_time((((vm - v0) * (vm - v0)) << 15) / (a * vm))
             + sat_time((((vm - v1) * (vm - v1)) << 15) / (d * vm));
      end else begin
         // triangle: peak where the two ramps meet
         q = rhs + d * v0 * v0 + a * v1 * v1;
         p = floor_sqrt(64'(q / (a + d)));
         if (p < v0 || p < v1) begin
            o.status = ST_PEAK_LOW;
            return o;
         end
         sum = sat_time(((p - v0) << 16) / a) + sat_time(((p - v1) << 16) / d);
      end
      o.travel_time = sat_time(sum);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         lim_speed = SPEED_CAP_RST;
         lim_accel = ACCEL_LIMIT_RST;
         lim_decel = DECEL_LIMIT_RST;
         expected_times.delete();
         error_count = 0;
      end else begin
         if (start && !busy) begin
            expected_times.insert(expected_times.size(), predict_travel(req_data));
         end
         if (rsp_valid) begin
            if (expected_times.size() == 0) begin
               $error("response with no request outstanding: time %0h status %0d",
                      rsp_data.travel_time, rsp_data.status);
               error_count++;
            end else begin
               want = expected_times.pop_front();
               if (rsp_data.travel_time !== want.travel_time) begin
                  $error("travel_time: expected %0h, got %0h",
                         want.travel_time, rsp_data.travel_time);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
            end
         end
         // limits change only while idle, so update after predicting
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SPEED_CAP:   lim_speed = csr_data;
               CSR_ACCEL_LIMIT: lim_accel = csr_data;
               CSR_DECEL_LIMIT: lim_decel = csr_data;
               default: ;
            endcase
         end
      end
      pending = expected_times.size();
   end

   initial begin
      error_count = 0;
      pending     = 0;
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb - testbench top for the trapezoid profile timer
// Drives requests and limit writes with random gaps through several limit
// settings; the checker predicts and compares every response.
// -----------------------------------------------------------------------------
module tb;
   import tpmt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 160;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_data  = '0;
   int          error_count, pending;
   int          cycle_count = 0;
   bit          quiet_phase;

   // stimulus-side copy of the limits, used only to shape requests
   logic [23:0] cur_speed, cur_accel, cur_decel;

   always #5 clock = ~clock;

   trapezoid_profile_min_time_core dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   tpmt_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .error_count, .pending
   );

   // watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // hold start low for a random gap; mostly short, a few long
   task automatic idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet_phase || pick < 65) return;
      if (pick < 95) repeat ($urandom_range(1, 3)) @(negedge clock);
      else           repeat ($urandom_range(10, 60)) @(negedge clock);
   endtask

   // one request transfer: present at the falling edge, hold until taken
   task automatic send_item(logic [31:0] len, logic [23:0] v0, logic [23:0] v1);
      req_data.path_length = len;
      req_data.speed_start = v0;
      req_data.speed_end   = v1;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
      idle_gap();
   endtask

   // wait until every expected response is in, then let the pipe settle
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_limit(logic [1:0] idx, logic [23:0] value);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         CSR_SPEED_CAP:   cur_speed = value;
         CSR_ACCEL_LIMIT: cur_accel = value;
         CSR_DECEL_LIMIT: cur_decel = value;
         default: ;
      endcase
   endtask

   task automatic set_limits(logic [23:0] vm, logic [23:0] a, logic [23:0] d);
      drain();
      write_limit(CSR_SPEED_CAP, vm);
      write_limit(CSR_ACCEL_LIMIT, a);
      write_limit(CSR_DECEL_LIMIT, d);
   endtask

   function automatic logic [23:0] rand_speed(logic [23:0] cap);
      case ($urandom_range(0, 4))
         0:       return cap;
         1:       return '0;
         2:       return 24'($urandom_range(0, 32'(cap) < 64 ? cap : 64));
         default: return 24'($urandom_range(0, cap));
      endcase
   endfunction

   // smallest length that allows the speed change between v0 and v1
   function automatic logic [63:0] min_length(logic [23:0] v0, logic [23:0] v1);
      logic [63:0] diff, lim;
      if (v1 > v0) begin
         diff = 64'(v1) * v1 - 64'(v0) * v0;
         lim  = 2 * 64'(cur_accel);
      end else begin
         diff = 64'(v0) * v0 - 64'(v1) * v1;
         lim  = 2 * 64'(cur_decel);
      end
      if (lim == 0) return '0;
      return (diff + lim - 1) / lim;
   endfunction

   task automatic random_item();
      logic [23:0] v0, v1;
      logic [63:0] need, len;
      int          pick;
      pick = $urandom_range(0, 99);
      v0   = rand_speed(cur_speed);
      v1   = rand_speed(cur_speed);
      need = min_length(v0, v1);
      if (pick < 60) begin
         // feasible: minimum length plus a slack of random scale
         case ($urandom_range(0, 3))
            0:       len = need;
            1:       len = need + $urandom_range(0, 255);
            2:       len = need + ($urandom() >> $urandom_range(0, 31));
            default: len = need + $urandom();
         endcase
         if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
         send_item(len[31:0], v0, v1);
      end else if (pick < 75) begin
         send_item($urandom(), 24'($urandom()), 24'($urandom()));
      end else if (pick < 85) begin
         // random speed above the cap, mixed in on entry or exit
         if (cur_speed != 24'hFF_FFFF) v0 = 24'($urandom_range(cur_speed + 1, 24'hFF_FFFF));
         send_item($urandom(), $urandom_range(0, 1) ? v0 : v1, $urandom_range(0, 1) ? v1 : v0);
      end else if (pick < 95) begin
         // one short of what the speed change needs
         len = (need > 1) ? need - 1 : 0;
         if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
         send_item(len[31:0], v0, v1);
      end else begin
         send_item('0, $urandom_range(0, 3) == 0 ? 24'd0 : v0, v1);
      end
   endtask

   // extremes and special cases under the current limits
   task automatic directed_items();
      logic [63:0] need;
      send_item('0, '0, '0);                         // zero length at rest
      send_item('0, cur_speed, '0);                  // zero length, moving
      send_item('0, '0, 24'd1);
      send_item(32'hFFFF_FFFF, '0, '0);              // longest path
      send_item(32'hFFFF_FFFF, cur_speed, cur_speed);
      send_item(32'd1, '0, '0);                      // shortest path
      send_item(32'd1, cur_speed, cur_speed);
      send_item($urandom(), cur_speed + 24'd1, '0);  // entry above non-max cap
      send_item($urandom(), '0, cur_speed + 24'd1);  // exit above non-max cap
      send_item($urandom(), 24'hFF_FFFF, 24'hFF_FFFF);
      need = min_length('0, cur_speed);              // accelerate, exact and short
      send_item(need[31:0], '0, cur_speed);
      send_item(need[31:0] - 32'd1, '0, cur_speed);
      need = min_length(cur_speed, '0);              // brake, exact and short
      send_item(need[31:0], cur_speed, '0);
      send_item(need[31:0] - 32'd1, cur_speed, '0);
      send_item(32'd64, '0, '0);                     // triangle
      send_item(32'h0100_0000, '0, '0);              // trapezoid
      send_item(32'h0001_0000, cur_speed >> 1, cur_speed >> 2);
   endtask

   task automatic random_phase(int count);
      repeat (count) begin
         if ($urandom_range(0, 199) == 0) quiet_phase = ~quiet_phase;
         random_item();
      end
      quiet_phase = 1'b0;
   endtask

   initial begin
      cur_speed   = SPEED_CAP_RST;
      cur_accel   = ACCEL_LIMIT_RST;
      cur_decel   = DECEL_LIMIT_RST;
      quiet_phase = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults after reset
      directed_items();
      random_phase(180);
      // sender holds off until everything has come back
      drain();
      random_phase(40);

      set_limits(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      directed_items();
      random_phase(180);

      set_limits(24'd1, 24'd1, 24'd1);
      random_phase(150);

      set_limits(24'h02_0000, 24'h03_0000, 24'h00_4000);
      random_phase(180);

      set_limits(24'h00_4000, 24'h00_0100, 24'h7F_0000);
      random_phase(180);

      set_limits('0, 24'h01_0000, 24'h01_0000);
      random_phase(60);
      set_limits(24'h01_0000, '0, 24'h01_0000);
      random_phase(60);
      set_limits(24'h01_0000, 24'h01_0000, '0);
      random_phase(60);

      repeat (3) begin
         set_limits(24'($urandom_range(1, 24'hFF_FFFF)), 24'($urandom_range(1, 24'hFF_FFFF)),
                    24'($urandom_range(1, 24'h00_FFFF)));
         random_phase(140);
      end

      drain();
      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (pending != 0) $error("%0d expected responses never arrived", pending);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
